### hw/rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg: frame presentation scheduler shared types
// Sizes, action codes, config register indexes, channel words and the
// controller command/status types.
// ----------------------------------------------------------------------------
package fps_pkg;
  localparam int QUEUE_SLOTS = 8;
  localparam int TAG_BITS    = 16;
  localparam int TIME_BITS   = 48;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TAKE  = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  localparam logic [2:0] REG_CAPACITY   = 3'd0;
  localparam logic [2:0] REG_PREBUF_CNT = 3'd1;
  localparam logic [2:0] REG_PREBUF_WT  = 3'd2;
  localparam logic [2:0] REG_DISCONT    = 3'd3;
  localparam logic [2:0] REG_REBASE     = 3'd4;
  localparam logic [2:0] REG_SLACK      = 3'd5;

  // input word
  typedef struct packed {
    action_t                action;
    logic [TIME_BITS-1:0]   now_us;
    logic [TIME_BITS-1:0]   frame_pts;
    logic [TAG_BITS-1:0]    frame_tag;
  } sched_in_t;

  // config word
  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } sched_cfg_t;

  // result word
  typedef struct packed {
    logic                   frame_valid;
    logic [TAG_BITS-1:0]    shown_tag;
    logic [TIME_BITS-1:0]   shown_pts;
    logic [3:0]             queue_depth;
    logic [31:0]            overflow_drops;
    logic [31:0]            late_skips;
    logic [31:0]            presented_count;
    logic [31:0]            rebase_count;
  } sched_out_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input word, clear result
    logic push_fix;  // fix pts against back slot, drop oldest while full
    logic push_wr;   // write slot, bump fill
    logic take_go;   // start check / anchor
    logic rebase;    // evaluate rebase
    logic first;     // take front as shown
    logic walk;      // take next due as shown (late)
    logic present;   // bump presented counter, set valid
    logic flush;
  } fps_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic start_ok;
    logic running;
    logic front_due;
    logic head_due;
  } fps_sts_t;
endpackage

### hw/rtl/fps_if.sv
// ----------------------------------------------------------------------------
// fps_if: valid/ready channel
// Carries one word of payload of type T.
// ----------------------------------------------------------------------------
interface fps_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/fps_ctrl.sv
// ----------------------------------------------------------------------------
// fps_ctrl: scheduler controller
// Sequences push, take and flush, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module fps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  fps_pkg::fps_sts_t  sts,
  output fps_pkg::fps_cmd_t  cmd
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FIX   = 8'b0000_0010,
    S_WR    = 8'b0000_0100,
    S_TAKE  = 8'b0000_1000,
    S_REB   = 8'b0001_0000,
    S_FIRST = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (fps_pkg::action_t'(in_action))
            fps_pkg::ACT_PUSH:  state_next = S_FIX;
            fps_pkg::ACT_TAKE:  state_next = S_TAKE;
            fps_pkg::ACT_FLUSH: begin
              cmd.flush = 1'b1;
              state_next = S_OUT;
            end
            default: state_next = S_OUT;
          endcase
        end
      end
      S_FIX: begin
        cmd.push_fix = 1'b1;
        if (!sts.full) state_next = S_WR;
      end
      S_WR: begin
        cmd.push_wr = 1'b1;
        state_next = S_OUT;
      end
      S_TAKE: begin
        if (sts.empty || (!sts.running && !sts.start_ok)) begin
          state_next = S_OUT;
        end else begin
          cmd.take_go = 1'b1;
          state_next = S_REB;
        end
      end
      S_REB: begin
        cmd.rebase = 1'b1;
        state_next = S_FIRST;
      end
      S_FIRST: begin
        if (sts.front_due) begin
          cmd.first = 1'b1;
          cmd.present = 1'b1;
          state_next = S_WALK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_WALK: begin
        if (!sts.empty && sts.head_due) cmd.walk = 1'b1;
        else state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
endmodule

### hw/rtl/fps_datapath.sv
// ----------------------------------------------------------------------------
// fps_datapath: scheduler datapath
// Frame ring, clock anchor, config registers and counters.
// ----------------------------------------------------------------------------
module fps_datapath #(
  parameter int QUEUE_SLOTS = fps_pkg::QUEUE_SLOTS,
  parameter int TAG_BITS    = fps_pkg::TAG_BITS,
  parameter int TIME_BITS   = fps_pkg::TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [TIME_BITS-1:0]  in_now,
  input  logic [TIME_BITS-1:0]  in_pts,
  input  logic [TAG_BITS-1:0]   in_tag,
  input  fps_pkg::fps_cmd_t     cmd,
  output fps_pkg::fps_sts_t     sts,
  output logic                  valid,
  output logic [TAG_BITS-1:0]   shown_tag,
  output logic [TIME_BITS-1:0]  shown_pts,
  output logic [3:0]            depth,
  output logic [31:0]           ovf_cnt,
  output logic [31:0]           late_cnt,
  output logic [31:0]           shown_cnt,
  output logic [31:0]           reb_cnt
);
  localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int FW = $clog2(QUEUE_SLOTS + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] slot_pts [QUEUE_SLOTS];
  logic [TAG_BITS-1:0]  slot_tag [QUEUE_SLOTS];
  logic [IW-1:0] head;
  logic [FW-1:0] fill;
  logic [3:0]  cap_r, pre_cnt;
  logic [23:0] pre_wait, reb_late;
  logic [31:0] discont;
  logic [15:0] slack;
  logic [TIME_BITS-1:0] now, pts, first_t, anc_wall, anc_strm;
  logic [TIME_BITS:0]   stream;  // one bit of headroom, anchor plus elapsed
  logic [TAG_BITS-1:0] tag;
  logic running;
  logic fix_done;  // pts fix and first-queued time only on the first fix cycle

  // ring index helpers (QUEUE_SLOTS may be non power of two)
  function automatic logic [IW-1:0] wrap(input logic [IW:0] v);
    logic [IW:0] r;
    r = v;
    if (r >= (IW+1)'(QUEUE_SLOTS)) r = r - (IW+1)'(QUEUE_SLOTS);
    return r[IW-1:0];
  endfunction

  logic [IW-1:0] head_nx, back_idx, tail_idx;
  assign head_nx  = wrap({1'b0, head} + 1'b1);
  assign tail_idx = wrap({1'b0, head} + (IW+1)'(fill));
  assign back_idx = wrap({1'b0, head} + (IW+1)'(fill) - 1'b1);

  // effective capacity
  logic [FW-1:0] cap;
  always_comb begin
    if (cap_r == 4'd0) cap = FW'(1);
    else if (32'(cap_r) > 32'(QUEUE_SLOTS)) cap = FW'(QUEUE_SLOTS);
    else cap = FW'(cap_r);
  end

  logic [TIME_BITS-1:0] front, hpts, el_first, el_anc;
  assign front    = slot_pts[head];
  assign hpts     = slot_pts[head];
  assign el_first = (now >= first_t)  ? now - first_t  : '0;
  assign el_anc   = (now >= anc_wall) ? now - anc_wall : '0;

  // stream time registered in take_go, so the rebase step has one add behind it
  logic [TIME_BITS:0] late_d;
  logic st_ge;
  assign st_ge  = stream >= {1'b0, front};
  assign late_d = st_ge ? stream - {1'b0, front} : {1'b0, front} - stream;
  logic do_reb;
  assign do_reb = st_ge ? (late_d > (TIME_BITS+1)'(discont) ||
                           late_d > (TIME_BITS+1)'(reb_late))
                        : (late_d > (TIME_BITS+1)'(discont));

  function automatic logic due(input logic [TIME_BITS-1:0] p,
                               input logic [TIME_BITS:0] s,
                               input logic [15:0] sl);
    return (s >= {1'b0, p}) || (({1'b0, p} - s) <= (TIME_BITS+1)'(sl));
  endfunction

  assign sts.empty     = (fill == '0);
  assign sts.full      = (fill >= cap);
  assign sts.running   = running;
  assign sts.start_ok  = (32'(fill) >= 32'(pre_cnt)) ||
                         (el_first >= TIME_BITS'(pre_wait));
  assign sts.front_due = due(front, stream, slack);
  assign sts.head_due  = due(hpts, stream, slack);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_r <= 4'd6; pre_cnt <= 4'd3; pre_wait <= 24'd150000;
      discont <= 32'd2000000; reb_late <= 24'd250000; slack <= 16'd2000;
      head <= '0; fill <= '0; first_t <= '0; anc_wall <= '0; anc_strm <= '0;
      running <= 1'b0; ovf_cnt <= '0; late_cnt <= '0; shown_cnt <= '0;
      reb_cnt <= '0; valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fps_pkg::REG_CAPACITY:   cap_r    <= cfg_data[3:0];
          fps_pkg::REG_PREBUF_CNT: pre_cnt  <= cfg_data[3:0];
          fps_pkg::REG_PREBUF_WT:  pre_wait <= cfg_data[23:0];
          fps_pkg::REG_DISCONT:    discont  <= cfg_data;
          fps_pkg::REG_REBASE:     reb_late <= cfg_data[23:0];
          fps_pkg::REG_SLACK:      slack    <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.load) valid <= 1'b0;
      if (cmd.flush) begin
        fill <= '0; running <= 1'b0;
      end
      if (cmd.push_fix) begin
        if (!fix_done && fill == '0) first_t <= now;
        if (fill >= cap) begin
          head <= head_nx; fill <= fill - 1'b1; ovf_cnt <= ovf_cnt + 1'b1;
        end
      end
      if (cmd.push_wr) fill <= fill + 1'b1;
      if (cmd.take_go) begin
        if (!running) begin
          anc_strm <= front; anc_wall <= now; running <= 1'b1;
          stream <= {1'b0, front};
        end else begin
          stream <= {1'b0, anc_strm} + {1'b0, el_anc};
        end
      end
      if (cmd.rebase && do_reb) begin
        anc_strm <= front; anc_wall <= now; stream <= {1'b0, front};
        reb_cnt <= reb_cnt + 1'b1;
      end
      if (cmd.first || cmd.walk) begin
        head <= head_nx; fill <= fill - 1'b1;
      end
      if (cmd.walk) late_cnt <= late_cnt + 1'b1;
      if (cmd.present) begin
        valid <= 1'b1; shown_cnt <= shown_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now <= in_now; pts <= in_pts; tag <= in_tag; fix_done <= 1'b0;
      shown_tag <= '0; shown_pts <= '0;
    end
    if (cmd.push_fix) begin
      fix_done <= 1'b1;
      if (!fix_done && fill != '0 && pts <= slot_pts[back_idx])
        pts <= (slot_pts[back_idx] < TMAX) ? slot_pts[back_idx] + 1'b1 : TMAX;
    end
    if (cmd.push_wr) begin
      slot_pts[tail_idx] <= pts; slot_tag[tail_idx] <= tag;
    end
    if (cmd.first || cmd.walk) begin
      shown_tag <= slot_tag[head]; shown_pts <= slot_pts[head];
    end
  end

  assign depth = 4'(fill);

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_SLOTS)) else $error("fill beyond ring");
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push_wr |-> fill < cap) else $error("push into full ring");
  a_valid_pres: assert property (@(posedge clk) disable iff (rst)
    cmd.present |=> valid) else $error("present lost");
endmodule

### hw/rtl/frame_presentation_scheduler.sv
// ----------------------------------------------------------------------------
// frame_presentation_scheduler: video frame presentation scheduler
// Frame ring with presentation clock; push, take and flush words.
// ----------------------------------------------------------------------------
// Use: words enter on in_ch (action, now_us, frame_pts, frame_tag); each
// gives exactly one result word on out_ch. Config words on cfg_ch set the
// six registers, index as listed; write only while idle.
// Sequence from acceptance to result: flush and the unused code go
// straight to the result; push fixes the stamp, drops the oldest frames
// while full, then writes; take goes straight to the result when the ring
// is empty or still prebuffering, else evaluates a rebase and, if the front
// frame is due, shows it and skips late frames (up to QUEUE_SLOTS-1). The
// controller walks the ring one slot a cycle. One word is in flight at a
// time; the next can be accepted in the cycle after its result is taken.
// When out_ch stalls the result register holds and in_ch stays not ready.
// Reset (rst, synchronous) empties the ring, stops the clock, zeroes the
// counters and loads the register defaults. Ring contents are not cleared.
// ----------------------------------------------------------------------------
module frame_presentation_scheduler (
  input logic clk,
  input logic rst,
  fps_if.sink   in_ch,
  fps_if.sink   cfg_ch,
  fps_if.source out_ch
);
  // in_ch.data: action, now_us, frame_pts, frame_tag
  // cfg_ch.data: index, value
  // out_ch.data: frame_valid, shown_tag, shown_pts, queue_depth and counters
  fps_pkg::fps_cmd_t cmd;
  fps_pkg::fps_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  fps_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_action(in_ch.data.action),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  fps_datapath u_dp (
    .clk, .rst,
    .cfg_we   (cfg_ch.valid),
    .cfg_index(cfg_ch.data.index),
    .cfg_data (cfg_ch.data.value),
    .in_now   (in_ch.data.now_us),
    .in_pts   (in_ch.data.frame_pts),
    .in_tag   (in_ch.data.frame_tag),
    .cmd, .sts,
    .valid    (out_ch.data.frame_valid),
    .shown_tag(out_ch.data.shown_tag),
    .shown_pts(out_ch.data.shown_pts),
    .depth    (out_ch.data.queue_depth),
    .ovf_cnt  (out_ch.data.overflow_drops),
    .late_cnt (out_ch.data.late_skips),
    .shown_cnt(out_ch.data.presented_count),
    .reb_cnt  (out_ch.data.rebase_count)
  );
endmodule

### dv/frame_presentation_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_presentation_scheduler_test: self-checking bench for the scheduler
// Directed then random push/take/flush words over several register settings,
// random gaps on both channels, every result checked against a predictor.
// ----------------------------------------------------------------------------
module frame_presentation_scheduler_test;
  localparam int SLOTS = fps_pkg::QUEUE_SLOTS;
  localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 20000;

  // Scoreboard: mirrors the ring and the presentation clock, queues the
  // result each accepted word should give.
  class frame_scoreboard;
    logic [3:0]  capacity, prebuf_cnt;
    logic [23:0] prebuf_wait, late_limit;
    logic [31:0] discont;
    logic [15:0] slack;
    logic [47:0] ring_pts [SLOTS];
    logic [15:0] ring_tag [SLOTS];
    int          head, fill;
    logic [63:0] first_time, anchor_wall, anchor_stream;
    bit          running;
    logic [31:0] n_overflow, n_late, n_shown, n_rebase;
    fps_pkg::sched_out_t expected_q [$];
    int          errors;

    function void reset_state();
      capacity = 4'd6; prebuf_cnt = 4'd3; prebuf_wait = 24'd150000;
      discont = 32'd2000000; late_limit = 24'd250000; slack = 16'd2000;
      head = 0; fill = 0; first_time = 0; anchor_wall = 0; anchor_stream = 0;
      running = 0; n_overflow = 0; n_late = 0; n_shown = 0; n_rebase = 0;
      expected_q.delete(); errors = 0;
    endfunction

    function void write_reg(fps_pkg::sched_cfg_t c);
      case (c.index)
        fps_pkg::REG_CAPACITY:   capacity   = c.value[3:0];
        fps_pkg::REG_PREBUF_CNT: prebuf_cnt = c.value[3:0];
        fps_pkg::REG_PREBUF_WT:  prebuf_wait = c.value[23:0];
        fps_pkg::REG_DISCONT:    discont    = c.value;
        fps_pkg::REG_REBASE:     late_limit = c.value[23:0];
        fps_pkg::REG_SLACK:      slack      = c.value[15:0];
        default: ;
      endcase
    endfunction

    function int slot(int off);
      return (head + off) % SLOTS;
    endfunction

    function logic [63:0] since(logic [63:0] now, logic [63:0] then_t);
      return (now >= then_t) ? now - then_t : 64'd0;
    endfunction

    function bit due(logic [63:0] pts, logic [63:0] stream);
      return stream >= pts || (pts - stream) <= {48'd0, slack};
    endfunction

    function void note_word(fps_pkg::sched_in_t w);
      fps_pkg::sched_out_t r;
      logic [63:0] now, pts, front, stream, lag;
      int          cap;
      bit          rebase;
      now = {16'd0, w.now_us};
      r = '0;
      case (w.action)
        fps_pkg::ACT_PUSH: begin
          pts = {16'd0, w.frame_pts};
          cap = capacity;
          if (cap < 1) cap = 1;
          if (cap > SLOTS) cap = SLOTS;
          if (fill == 0) first_time = now;
          else if (pts <= ring_pts[slot(fill - 1)])
            pts = (ring_pts[slot(fill - 1)] < TIME_TOP) ?
                  ring_pts[slot(fill - 1)] + 1 : TIME_TOP;
          while (fill >= cap) begin
            head = slot(1); fill--; n_overflow++;
          end
          ring_pts[slot(fill)] = pts[47:0];
          ring_tag[slot(fill)] = w.frame_tag;
          fill++;
        end
        fps_pkg::ACT_TAKE: if (fill > 0) begin
          front = ring_pts[head];
          if (!running && !(fill < prebuf_cnt && since(now, first_time) < prebuf_wait))
          begin
            anchor_stream = front; anchor_wall = now; running = 1;
          end
          if (running) begin
            stream = anchor_stream + since(now, anchor_wall);
            if (stream >= front) begin
              lag = stream - front;
              rebase = lag > discont || lag > late_limit;
            end else begin
              rebase = front - stream > discont;
            end
            if (rebase) begin
              anchor_stream = front; anchor_wall = now; stream = front; n_rebase++;
            end
            if (due(front, stream)) begin
              r.frame_valid = 1;
              r.shown_tag = ring_tag[head]; r.shown_pts = ring_pts[head];
              head = slot(1); fill--;
              while (fill > 0 && due(ring_pts[head], stream)) begin
                r.shown_tag = ring_tag[head]; r.shown_pts = ring_pts[head];
                head = slot(1); fill--; n_late++;
              end
              n_shown++;
            end
          end
        end
        fps_pkg::ACT_FLUSH: begin
          fill = 0; running = 0;
        end
        default: ;
      endcase
      r.queue_depth = fill[3:0];
      r.overflow_drops = n_overflow; r.late_skips = n_late;
      r.presented_count = n_shown;  r.rebase_count = n_rebase;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(fps_pkg::sched_out_t a);
      fps_pkg::sched_out_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      compare("frame_valid", e.frame_valid, a.frame_valid);
      compare("shown_tag", e.shown_tag, a.shown_tag);
      compare("shown_pts", e.shown_pts, a.shown_pts);
      compare("queue_depth", e.queue_depth, a.queue_depth);
      compare("overflow_drops", e.overflow_drops, a.overflow_drops);
      compare("late_skips", e.late_skips, a.late_skips);
      compare("presented_count", e.presented_count, a.presented_count);
      compare("rebase_count", e.rebase_count, a.rebase_count);
    endfunction
  endclass

  logic clk;
  logic rst;

  fps_if #(.T(fps_pkg::sched_in_t))  in_ch  ();
  fps_if #(.T(fps_pkg::sched_cfg_t)) cfg_ch ();
  fps_if #(.T(fps_pkg::sched_out_t)) out_ch ();

  frame_presentation_scheduler uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard board = new();

  // stimulus time base
  logic [47:0] wall_now;
  logic [47:0] stream_pts;
  bit          no_gaps;      // stretches with back-to-back words
  bit          hold_done;    // long receiver stall already done
  bit          stim_done;
  int          idle_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, a few long ones.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one frame word and wait for it to be taken.
  task automatic send_word(fps_pkg::action_t act, logic [47:0] now,
                           logic [47:0] pts, logic [15:0] tag);
    fps_pkg::sched_in_t w;
    int gap;
    w.action = act; w.now_us = now; w.frame_pts = pts; w.frame_tag = tag;
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(w);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    fps_pkg::sched_cfg_t c;
    c.index = idx; c.value = val;
    cfg_ch.data  <= c;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.write_reg(c);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers only change once every result is back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic load_regs(logic [3:0] cap, logic [3:0] pre, logic [23:0] wt,
                           logic [31:0] dis, logic [23:0] late, logic [15:0] sl);
    drain();
    write_reg(fps_pkg::REG_CAPACITY, 32'(cap));
    write_reg(fps_pkg::REG_PREBUF_CNT, 32'(pre));
    write_reg(fps_pkg::REG_PREBUF_WT, 32'(wt));
    write_reg(fps_pkg::REG_DISCONT, dis);
    write_reg(fps_pkg::REG_REBASE, 32'(late));
    write_reg(fps_pkg::REG_SLACK, 32'(sl));
  endtask

  // One random word: mostly a steady stream of frames at video rate with
  // takes paced against it, plus jumps, stale stamps, flushes and noise.
  task automatic random_word();
    int r;
    logic [47:0] pts;
    r = $urandom_range(0, 99);
    if (r < 90) wall_now += 48'($urandom_range(0, 20000));
    else if (r < 97) wall_now += 48'($urandom_range(0, 3000000));
    else if (wall_now > 60000) wall_now -= 48'($urandom_range(0, 50000));
    r = $urandom_range(0, 99);
    if (r < 47) begin
      stream_pts += 48'($urandom_range(20000, 45000));
      pts = stream_pts;
      case ($urandom_range(0, 19))
        0: pts = stream_pts - 48'($urandom_range(0, 100000));
        1: pts = 48'({$urandom, $urandom});
        2: begin
          stream_pts += 48'($urandom_range(0, 5000000));
          pts = stream_pts;
        end
        default: ;
      endcase
      send_word(fps_pkg::ACT_PUSH, wall_now, pts, 16'($urandom));
    end else if (r < 94) begin
      send_word(fps_pkg::ACT_TAKE, wall_now, 48'({$urandom, $urandom}),
                16'($urandom));
    end else if (r < 98) begin
      send_word(fps_pkg::ACT_FLUSH, wall_now, 48'({$urandom, $urandom}),
                16'($urandom));
    end else begin
      send_word(fps_pkg::ACT_NONE, wall_now, 48'({$urandom, $urandom}),
                16'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
      random_word();
    end
  endtask

  // Stimulus.
  initial begin
    rst = 1'b1;
    in_ch.valid  = 1'b0; in_ch.data  = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    board.reset_state();
    wall_now = 48'd1000; stream_pts = 48'd0;
    no_gaps = 0; stim_done = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty take, unused code, stale stamps, overfill at default
    // capacity, prebuffer start, flush, wall time going backwards
    send_word(fps_pkg::ACT_TAKE, 48'd1000, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_NONE, 48'd1000, TIME_TOP, 16'hFFFF);
    send_word(fps_pkg::ACT_PUSH, 48'd1000, 48'd5000, 16'h0001);
    send_word(fps_pkg::ACT_PUSH, 48'd1100, 48'd5000, 16'h0002);
    send_word(fps_pkg::ACT_PUSH, 48'd1200, 48'd0, 16'h0003);
    for (int i = 0; i < 5; i++)
      send_word(fps_pkg::ACT_PUSH, 48'd1300, 48'(48'd40000 * (i + 1)),
                16'(16'hA000 + i));
    send_word(fps_pkg::ACT_TAKE, 48'd2000, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_TAKE, 48'd1500, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_TAKE, 48'd200000, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_FLUSH, 48'd200000, 48'd0, 16'd0);
    // timestamp saturation at the top of the range
    send_word(fps_pkg::ACT_PUSH, TIME_TOP - 48'd1, TIME_TOP - 48'd1, 16'h5555);
    send_word(fps_pkg::ACT_PUSH, TIME_TOP, 48'd3, 16'hAAAA);
    send_word(fps_pkg::ACT_PUSH, TIME_TOP, 48'd3, 16'h1234);
    send_word(fps_pkg::ACT_TAKE, TIME_TOP, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_TAKE, 48'd0, 48'd0, 16'd0);
    send_word(fps_pkg::ACT_FLUSH, 48'd300000, 48'd0, 16'd0);
    wall_now = 48'd300000; stream_pts = 48'd300000;

    random_phase(250);
    // extremes: zero capacity acts as one, zero prebuffer, zero windows
    load_regs(4'd0, 4'd0, 24'd0, 32'd0, 24'd0, 16'd0);
    random_phase(200);
    load_regs(4'd15, 4'd15, 24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF);
    random_phase(200);
    load_regs(4'd8, 4'd8, 24'd100000, 32'd500000, 24'd80000, 16'd10000);
    random_phase(250);
    load_regs(4'd1, 4'd1, 24'd30000, 32'd3000000, 24'd300000, 16'd0);
    random_phase(200);
    load_regs(4'd4, 4'd2, 24'd50000, 32'd1000000, 24'd100000, 16'd5000);
    random_phase(250);
    load_regs(4'd6, 4'd3, 24'd150000, 32'd2000000, 24'd250000, 16'd2000);
    random_phase(480);
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, one long hold-off while the sender keeps going.
  initial begin
    int r, n;
    out_ch.ready = 1'b0;
    hold_done = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!hold_done && board.n_shown > 20) begin
        hold_done = 1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) n = 0;
      else if (r < 93) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 40);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  // Watchdog on cycles with no handshake on any channel, plus the end check.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (out_ch.valid && out_ch.ready) || rst)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout, %0d results outstanding", board.expected_q.size());
        $display("*** FAILED ***");
        $finish;
      end
      if (stim_done && board.expected_q.size() == 0) begin
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
          $display("*** PASSED ***");
        end else begin
          $display("*** FAILED ***");
        end
        $finish;
      end
    end
  end
endmodule
